// ===== sv/ppp_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the point
// projection pipeline. No dependencies.
package ppp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 84;
  localparam int SCREEN_HEIGHT_DEF = 48;
  localparam int COORD_BITS_DEF    = 10;

  localparam int TRIG_W  = 16;
  localparam int ZOOM    = 40;
  localparam int FRAC_W  = 15;
  localparam int ANG_W   = 9;
  localparam int DEG_90  = 90;
  localparam int DEG_360 = 360;
  localparam int SCR_W   = 16;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_CAM_X       = 2'd0,
    REG_CAM_Y       = 2'd1,
    REG_CAM_Z       = 2'd2,
    REG_CAM_HEADING = 2'd3
  } ppp_reg_t;

  typedef struct packed {
    logic              front;
    logic              neg_x;
    logic              neg_y;
    logic [SCR_W-1:0]  fb_x;
    logic [SCR_W-1:0]  fb_y;
  } ppp_tag_t;

  localparam logic [TRIG_W-1:0] QSINE [91] = '{
    16'd0, 16'd571, 16'd1143, 16'd1714, 16'd2285, 16'd2855, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6812, 16'd7371, 16'd7927,
    16'd8480, 16'd9032, 16'd9580, 16'd10125, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13327, 16'd13848, 16'd14364, 16'd14876,
    16'd15383, 16'd15886, 16'd16384, 16'd16876, 16'd17364, 16'd17846,
    16'd18323, 16'd18794, 16'd19260, 16'd19720, 16'd20173, 16'd20621,
    16'd21062, 16'd21497, 16'd21926, 16'd22347, 16'd22762, 16'd23170,
    16'd23571, 16'd23964, 16'd24351, 16'd24730, 16'd25101, 16'd25465,
    16'd25821, 16'd26169, 16'd26509, 16'd26841, 16'd27165, 16'd27481,
    16'd27788, 16'd28087, 16'd28377, 16'd28659, 16'd28932, 16'd29196,
    16'd29451, 16'd29697, 16'd29935, 16'd30163, 16'd30381, 16'd30591,
    16'd30791, 16'd30982, 16'd31164, 16'd31336, 16'd31498, 16'd31651,
    16'd31794, 16'd31928, 16'd32051, 16'd32165, 16'd32270, 16'd32364,
    16'd32449, 16'd32523, 16'd32588, 16'd32643, 16'd32688, 16'd32723,
    16'd32748, 16'd32763, 16'd32767
  };

  // angle already reduced below 360
  function automatic logic signed [TRIG_W-1:0] q15_sine(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0]   idx;
    logic               neg;
    logic [TRIG_W-1:0]  mag;
    if (a < ANG_W'(DEG_90)) begin
      idx = a;
      neg = 1'b0;
    end else if (a < ANG_W'(2*DEG_90)) begin
      idx = ANG_W'(2*DEG_90) - a;
      neg = 1'b0;
    end else if (a < ANG_W'(3*DEG_90)) begin
      idx = a - ANG_W'(2*DEG_90);
      neg = 1'b1;
    end else begin
      idx = ANG_W'(DEG_360) - a;
      neg = 1'b1;
    end
    mag = QSINE[idx[6:0]];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== sv/ppp_if.sv =====
// Valid/ready channel interfaces for points in and projected results out.
// Depends on ppp_pkg.
interface ppp_in_if #(parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppp_pkg::SCR_W-1:0]   screen_x;
  logic signed [ppp_pkg::SCR_W-1:0]   screen_y;
  logic                               ahead;
  modport source (output valid, screen_x, screen_y, ahead, input ready);
  modport sink   (input valid, screen_x, screen_y, ahead, output ready);
endinterface

// ===== sv/ppp_front.sv =====
// Transform stages: camera offset and trig lookup, products, rotation sums,
// zoom scaling, then magnitudes and the orthographic fallback. Uses ppp_pkg.
module ppp_front #(
  parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF,
  parameter int COORD_BITS    = ppp_pkg::COORD_BITS_DEF,
  parameter int NW            = COORD_BITS + 24,
  parameter int DW            = COORD_BITS + 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [COORD_BITS-1:0]         px,
  input  logic [COORD_BITS-1:0]         py,
  input  logic [COORD_BITS-1:0]         pz,
  input  logic [COORD_BITS-1:0]         cam_x,
  input  logic [COORD_BITS-1:0]         cam_y,
  input  logic [COORD_BITS-1:0]         cam_z,
  input  logic [ppp_pkg::ANG_W-1:0]     cam_heading,
  output logic                          out_vld,
  output logic [NW-1:0]                 mag_x,
  output logic [NW-1:0]                 mag_y,
  output logic [DW-1:0]                 den,
  output ppp_pkg::ppp_tag_t             tag
);

  localparam int RW = COORD_BITS + 1;
  localparam int PW = RW + ppp_pkg::TRIG_W;
  localparam int SW = NW + 1;
  localparam int HALF_X = SCREEN_WIDTH / 2;
  localparam int HALF_Y = SCREEN_HEIGHT / 2;
  localparam int SCR_W_L = ppp_pkg::SCR_W;
  localparam logic signed [SW-1:0] SMAX = SW'(32767);
  localparam logic signed [SW-1:0] SMIN = -SW'(32768);

  logic [4:0] vld_r;

  // stage 1
  logic signed [RW-1:0]               rx_r, ry_r, rz_r;
  logic signed [ppp_pkg::TRIG_W-1:0]  s_r, c_r;
  logic [ppp_pkg::ANG_W-1:0]          a_nxt, b_nxt, b_raw;
  // stage 2
  logic signed [PW-1:0] crx_r, srz_r, crz_r, srx_r;
  logic signed [RW-1:0] ry2_r;
  // stage 3
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  // stage 4
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [DW-1:0] dz4_r;
  logic                 front4_r;
  // stage 5
  logic [NW-1:0]        mag_x_r, mag_y_r;
  logic [DW-1:0]        den_r;
  ppp_pkg::ppp_tag_t    tag_r;
  logic signed [SW-1:0] fx_nxt, fy_nxt;

  always_comb begin
    a_nxt = (cam_heading >= ppp_pkg::ANG_W'(ppp_pkg::DEG_360)) ?
            cam_heading - ppp_pkg::ANG_W'(ppp_pkg::DEG_360) : cam_heading;
    b_raw = a_nxt + ppp_pkg::ANG_W'(ppp_pkg::DEG_90);
    b_nxt = (b_raw >= ppp_pkg::ANG_W'(ppp_pkg::DEG_360)) ?
            b_raw - ppp_pkg::ANG_W'(ppp_pkg::DEG_360) : b_raw;
    fx_nxt = SW'(nx_r >>> ppp_pkg::FRAC_W) + SW'(HALF_X);
    fy_nxt = SW'(ny_r >>> ppp_pkg::FRAC_W) + SW'(HALF_Y);
    if (fx_nxt > SMAX) fx_nxt = SMAX;
    if (fx_nxt < SMIN) fx_nxt = SMIN;
    if (fy_nxt > SMAX) fy_nxt = SMAX;
    if (fy_nxt < SMIN) fy_nxt = SMIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= $signed({1'b0, px}) - $signed({1'b0, cam_x});
      ry_r <= $signed({1'b0, py}) - $signed({1'b0, cam_y});
      rz_r <= $signed({1'b0, pz}) - $signed({1'b0, cam_z});
      s_r  <= ppp_pkg::q15_sine(a_nxt);
      c_r  <= ppp_pkg::q15_sine(b_nxt);

      crx_r <= PW'(c_r * rx_r);
      srz_r <= PW'(s_r * rz_r);
      crz_r <= PW'(c_r * rz_r);
      srx_r <= PW'(s_r * rx_r);
      ry2_r <= ry_r;

      dx_r <= DW'(crx_r) - DW'(srz_r);
      dz_r <= DW'(crz_r) + DW'(srx_r);
      dy_r <= DW'($signed({ry2_r, {ppp_pkg::FRAC_W{1'b0}}}));

      nx_r     <= (NW'(dx_r) <<< 5) + (NW'(dx_r) <<< 3);
      ny_r     <= (NW'(dy_r) <<< 5) + (NW'(dy_r) <<< 3);
      dz4_r    <= dz_r;
      front4_r <= (dz_r > 0);

      mag_x_r     <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      mag_y_r     <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      den_r       <= front4_r ? DW'(dz4_r) : DW'(1);
      tag_r.front <= front4_r;
      tag_r.neg_x <= nx_r[NW-1];
      tag_r.neg_y <= ny_r[NW-1];
      tag_r.fb_x  <= fx_nxt[SCR_W_L-1:0];
      tag_r.fb_y  <= fy_nxt[SCR_W_L-1:0];
    end
  end

  assign out_vld = vld_r[4];
  assign mag_x   = mag_x_r;
  assign mag_y   = mag_y_r;
  assign den     = den_r;
  assign tag     = tag_r;

endmodule

// ===== sv/ppp_div.sv =====
// Two-lane restoring divider, one quotient bit per pipeline stage, shared
// divisor; the side tag travels with each transaction. Uses ppp_pkg.
module ppp_div #(
  parameter int NW = ppp_pkg::COORD_BITS_DEF + 24,
  parameter int DW = ppp_pkg::COORD_BITS_DEF + 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [NW-1:0]      num_x,
  input  logic [NW-1:0]      num_y,
  input  logic [DW-1:0]      den,
  input  ppp_pkg::ppp_tag_t  tag_in,
  output logic               out_vld,
  output logic [NW-1:0]      q_x,
  output logic [NW-1:0]      q_y,
  output ppp_pkg::ppp_tag_t  tag_out
);

  logic [NW-1:0]     nx_r  [NW+1];
  logic [NW-1:0]     ny_r  [NW+1];
  logic [DW-1:0]     rx_r  [NW+1];
  logic [DW-1:0]     ry_r  [NW+1];
  logic [NW-1:0]     qx_r  [NW+1];
  logic [NW-1:0]     qy_r  [NW+1];
  logic [DW-1:0]     den_r [NW+1];
  ppp_pkg::ppp_tag_t tag_r [NW+1];
  logic [NW:0]       vld_r;

  assign nx_r[0]  = num_x;
  assign ny_r[0]  = num_y;
  assign rx_r[0]  = '0;
  assign ry_r[0]  = '0;
  assign qx_r[0]  = '0;
  assign qy_r[0]  = '0;
  assign den_r[0] = den;
  assign tag_r[0] = tag_in;
  assign vld_r[0] = in_vld;

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DW-1:0] shx, shy;
    logic [DW:0]   dfx, dfy;
    always_comb begin
      shx = {rx_r[k-1][DW-2:0], nx_r[k-1][NW-k]};
      shy = {ry_r[k-1][DW-2:0], ny_r[k-1][NW-k]};
      dfx = {1'b0, shx} - {1'b0, den_r[k-1]};
      dfy = {1'b0, shy} - {1'b0, den_r[k-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[k]  <= nx_r[k-1];
        ny_r[k]  <= ny_r[k-1];
        rx_r[k]  <= dfx[DW] ? shx : dfx[DW-1:0];
        ry_r[k]  <= dfy[DW] ? shy : dfy[DW-1:0];
        qx_r[k]  <= {qx_r[k-1][NW-2:0], ~dfx[DW]};
        qy_r[k]  <= {qy_r[k-1][NW-2:0], ~dfy[DW]};
        den_r[k] <= den_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign q_x     = qx_r[NW];
  assign q_y     = qy_r[NW];
  assign tag_out = tag_r[NW];

endmodule

// ===== sv/perspective_point_projection_unit.sv =====
// Top level: configuration registers, transform front end, divider and
// output register. Uses ppp_pkg, ppp_if, ppp_front and ppp_div.
//
//  channel  dir  ports                                  handshake
//  in_ch    in   point_x, point_y, point_z              valid/ready
//  out_ch   out  screen_x, screen_y, ahead              valid/ready
//  cfg      in   cfg_we, cfg_idx, cfg_wdata             write enable
//
// One point per cycle while the output is not stalled; the divider yields one
// quotient bit per stage. Synchronous reset clears valid bits and the camera
// registers. A stalled output freezes the whole pipeline.
module perspective_point_projection_unit #(
  parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF,
  parameter int COORD_BITS    = ppp_pkg::COORD_BITS_DEF,
  localparam int CFG_W = (COORD_BITS > ppp_pkg::ANG_W) ? COORD_BITS : ppp_pkg::ANG_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ppp_in_if.sink                        in_ch,
  ppp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ppp_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  localparam int DW     = COORD_BITS + 18;
  localparam int NW     = DW + 6;
  localparam int SW     = NW + 2;
  localparam int HALF_X = SCREEN_WIDTH / 2;
  localparam int HALF_Y = SCREEN_HEIGHT / 2;
  localparam logic signed [SW-1:0] SMAX = SW'(32767);
  localparam logic signed [SW-1:0] SMIN = -SW'(32768);

  logic [COORD_BITS-1:0]          cam_x_r, cam_y_r, cam_z_r;
  logic [ppp_pkg::ANG_W-1:0]      cam_heading_r;
  logic                           en;
  logic                           f_vld, d_vld;
  logic [NW-1:0]                  mag_x, mag_y, q_x, q_y;
  logic [DW-1:0]                  den;
  ppp_pkg::ppp_tag_t              f_tag, d_tag;
  logic signed [SW-1:0]           sx_nxt, sy_nxt;
  logic                           out_valid_r;
  logic [ppp_pkg::SCR_W-1:0]      sx_r, sy_r;
  logic                           front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r       <= '0;
      cam_y_r       <= '0;
      cam_z_r       <= '0;
      cam_heading_r <= '0;
    end else if (cfg_we) begin
      unique case (ppp_pkg::ppp_reg_t'(cfg_idx))
        ppp_pkg::REG_CAM_X:       cam_x_r <= cfg_wdata[COORD_BITS-1:0];
        ppp_pkg::REG_CAM_Y:       cam_y_r <= cfg_wdata[COORD_BITS-1:0];
        ppp_pkg::REG_CAM_Z:       cam_z_r <= cfg_wdata[COORD_BITS-1:0];
        ppp_pkg::REG_CAM_HEADING: cam_heading_r <= cfg_wdata[ppp_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  ppp_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .COORD_BITS   (COORD_BITS),
    .NW           (NW),
    .DW           (DW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_ch.valid),
    .px         (in_ch.point_x),
    .py         (in_ch.point_y),
    .pz         (in_ch.point_z),
    .cam_x      (cam_x_r),
    .cam_y      (cam_y_r),
    .cam_z      (cam_z_r),
    .cam_heading(cam_heading_r),
    .out_vld    (f_vld),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .den        (den),
    .tag        (f_tag)
  );

  ppp_div #(.NW(NW), .DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (f_vld),
    .num_x  (mag_x),
    .num_y  (mag_y),
    .den    (den),
    .tag_in (f_tag),
    .out_vld(d_vld),
    .q_x    (q_x),
    .q_y    (q_y),
    .tag_out(d_tag)
  );

  always_comb begin
    sx_nxt = (d_tag.neg_x ? -SW'(q_x) : SW'(q_x)) + SW'(HALF_X);
    sy_nxt = (d_tag.neg_y ? -SW'(q_y) : SW'(q_y)) + SW'(HALF_Y);
    if (sx_nxt > SMAX) sx_nxt = SMAX;
    if (sx_nxt < SMIN) sx_nxt = SMIN;
    if (sy_nxt > SMAX) sy_nxt = SMAX;
    if (sy_nxt < SMIN) sy_nxt = SMIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r    <= d_tag.front ? sx_nxt[ppp_pkg::SCR_W-1:0] : d_tag.fb_x;
      sy_r    <= d_tag.front ? sy_nxt[ppp_pkg::SCR_W-1:0] : d_tag.fb_y;
      front_r <= d_tag.front;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.screen_x = $signed(sx_r);
  assign out_ch.screen_y = $signed(sy_r);
  assign out_ch.ahead    = front_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipeline blocked with empty output");

endmodule
